>>> rtl/core/dedup_event_queue_assert.svh
// Assertion macros shared by the deduplicating event queue RTL.
`ifndef DEDUP_EVENT_QUEUE_ASSERT_SVH
`define DEDUP_EVENT_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deq assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deq assertion failed in the next cycle");

`endif

>>> rtl/core/deq_pkg.sv
// Package with the types and constants of the deduplicating event queue.
package deq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int EVENT_BITS  = 8;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CMD_W       = 2;
   localparam int EVENT_IN_W  = 8;
   localparam int STATUS_W    = 3;
   localparam int EVENT_OUT_W = 8;

   typedef logic [PTR_BITS-1:0]    ptr_type;
   typedef logic [EVENT_BITS-1:0]  id_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_POST    = 2'd0,
      CMD_CONSUME = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED    = 3'd0,
      ST_PENDING   = 3'd1,
      ST_REJECTED  = 3'd2,
      ST_DELIVERED = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_RESTARTED = 3'd5
   } status_type;

   typedef struct packed {
      logic    en;
      ptr_type addr;
      id_type  data;
   } slot_wr_type;

endpackage

>>> rtl/core/dedup_event_queue.sv
// Deduplicating event queue: a ring of event ids in one memory, scanned on each post to a
// queue that is neither empty nor full, from the head until the id or the tail is found.
// A consume first reads the head slot through the registered read port of the memory.
// Restart and rejected requests go straight to the result; one request is handled at a time.
// Synchronous reset empties the queue and clears rsp_tvalid; slot contents are not cleared.
`include "dedup_event_queue_assert.svh"

module dedup_event_queue
   import deq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [EVENT_IN_W-1:0]  req_tdata,   // [7:0] event_id
   input  logic [CMD_W-1:0]       req_tuser,   // [1:0] cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [EVENT_OUT_W-1:0] rsp_tdata,   // [7:0] event_out
   output logic [STATUS_W-1:0]    rsp_tuser    // [2:0] status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_POP,
      S_RESULT
   } state_type;

   state_type                state_ff, state_in;
   ptr_type                  head_ff, head_in;
   ptr_type                  tail_ff, tail_in;
   ptr_type                  scan_ff, scan_in;
   logic                     full_ff, full_in;
   logic                     empty_ff, empty_in;
   id_type                   id_ff, id_in;
   status_type               res_status_ff, res_status_in;
   logic [EVENT_OUT_W-1:0]   res_event_ff, res_event_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [EVENT_OUT_W-1:0]   rsp_event_ff, rsp_event_in;

   slot_wr_type wr;
   ptr_type     rd_addr;
   id_type      rd_data;
   ptr_type     head_inc;
   ptr_type     tail_inc;
   ptr_type     scan_inc;
   id_type      req_id;
   logic        out_free;

   deq_slot_ram u_slot_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign head_inc   = ptr_type'(head_ff + 1'b1);
   assign tail_inc   = ptr_type'(tail_ff + 1'b1);
   assign scan_inc   = ptr_type'(scan_ff + 1'b1);
   assign req_id     = id_type'(req_tdata);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      scan_in       = scan_ff;
      full_in       = full_ff;
      empty_in      = empty_ff;
      id_in         = id_ff;
      res_status_in = res_status_ff;
      res_event_in  = res_event_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_event_in  = rsp_event_ff;
      wr            = '0;
      rd_addr       = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               id_in        = req_id;
               res_event_in = '0;
               case (cmd_type'(req_tuser))
                  CMD_POST: begin
                     if (full_ff) begin
                        res_status_in = ST_REJECTED;
                        state_in      = S_RESULT;
                     end else if (empty_ff) begin
                        wr.en         = 1'b1;
                        wr.addr       = tail_ff;
                        wr.data       = req_id;
                        tail_in       = tail_inc;
                        empty_in      = 1'b0;
                        full_in       = (tail_inc == head_ff);
                        res_status_in = ST_QUEUED;
                        state_in      = S_RESULT;
                     end else begin
                        rd_addr  = head_ff;
                        scan_in  = head_ff;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_CONSUME: begin
                     if (empty_ff) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RESULT;
                     end else begin
                        rd_addr  = head_ff;
                        state_in = S_POP;
                     end
                  end
                  CMD_RESTART: begin
                     head_in       = '0;
                     tail_in       = '0;
                     full_in       = 1'b0;
                     empty_in      = 1'b1;
                     res_status_in = ST_RESTARTED;
                     state_in      = S_RESULT;
                  end
                  default: begin
                     res_status_in = ST_REJECTED;
                     state_in      = S_RESULT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_data == id_ff) begin
               res_status_in = ST_PENDING;
               state_in      = S_RESULT;
            end else if (scan_inc == tail_ff) begin
               wr.en         = 1'b1;
               wr.addr       = tail_ff;
               wr.data       = id_ff;
               tail_in       = tail_inc;
               empty_in      = 1'b0;
               full_in       = (tail_inc == head_ff);
               res_status_in = ST_QUEUED;
               state_in      = S_RESULT;
            end else begin
               rd_addr = scan_inc;
               scan_in = scan_inc;
            end
         end
         S_POP: begin
            res_event_in  = EVENT_OUT_W'(rd_data);
            head_in       = head_inc;
            full_in       = 1'b0;
            empty_in      = (head_inc == tail_ff);
            res_status_in = ST_DELIVERED;
            state_in      = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_event_in  = res_event_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         full_ff      <= 1'b0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         full_ff      <= full_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      id_ff         <= id_in;
      res_status_ff <= res_status_in;
      res_event_ff  <= res_event_in;
      rsp_status_ff <= rsp_status_in;
      rsp_event_ff  <= rsp_event_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_event_ff;
   assign rsp_tuser  = rsp_status_ff;

   `DEQ_ASSERT_SAME(a_flags_exclusive, clock, reset, 1'b1, !(full_ff && empty_ff))
   `DEQ_ASSERT_SAME(a_flags_pointers, clock, reset, full_ff || empty_ff, head_ff == tail_ff)
   `DEQ_ASSERT_SAME(a_scan_nonempty, clock, reset, state_ff == S_SCAN, !full_ff && !empty_ff)
   `DEQ_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE)

endmodule

>>> rtl/core/deq_slot_ram.sv
// Slot memory of the event queue: one write port and one registered read port.
module deq_slot_ram
   import deq_pkg::*;
(
   input  logic        clock,
   input  slot_wr_type wr,
   input  ptr_type     rd_addr,
   output id_type      rd_data
);

   id_type mem [QUEUE_DEPTH];
   id_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
